// File: hdl/prqs_pkg.sv
`default_nettype none
package prqs_pkg;

    typedef enum logic [1:0] {
        CMD_MAKE_READY = 2'd0,
        CMD_SCHEDULE   = 2'd1,
        CMD_MR_SCHED   = 2'd2,
        CMD_BLOCK      = 2'd3
    } cmd_code_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic block_cur;
        logic ap_rd;
        logic ap_wr;
        logic sel_cur;
        logic pick;
        logic pop_chk;
        logic pop_wr;
    } dp_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic ap_ok;
        logic requeue;
        logic any_ready;
        logic last;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/prqs_ram.sv
`default_nettype none
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: hdl/prqs_ctrl.sv
`default_nettype none
module prqs_ctrl
    import prqs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] cmd,
    input  wire dp_stat_t   stat,
    output dp_ctl_t         ctl,
    output logic            busy,
    output logic            done
);
    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_AP_RD, S_AP_WR, S_SCHED, S_RQ_RD, S_RQ_WR,
        S_PICK, S_POP_CHK, S_POP_WR, S_FIN
    } state_t;

    state_t    state_reg, state_next;
    cmd_code_t cmd_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (start) state_next = S_DISP;
            S_DISP:
            begin
                case (cmd_reg)
                    CMD_MAKE_READY: state_next = stat.ap_ok ? S_AP_RD : S_FIN;
                    CMD_MR_SCHED:   state_next = stat.ap_ok ? S_AP_RD : S_SCHED;
                    default:        state_next = S_SCHED;
                endcase
            end
            S_AP_RD:   state_next = S_AP_WR;
            S_AP_WR:   state_next = (cmd_reg == CMD_MAKE_READY) ? S_FIN : S_SCHED;
            S_SCHED:   state_next = stat.requeue ? S_RQ_RD : S_PICK;
            S_RQ_RD:   state_next = S_RQ_WR;
            S_RQ_WR:   state_next = S_PICK;
            S_PICK:    state_next = stat.any_ready ? S_POP_CHK : S_FIN;
            S_POP_CHK: state_next = stat.last ? S_FIN : S_POP_WR;
            S_POP_WR:  state_next = S_FIN;
            S_FIN:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_MAKE_READY;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                cmd_reg <= cmd_code_t'(cmd);
            end
        end
    end

    always_comb
    begin
        ctl.load      = (state_reg == S_IDLE) && start;
        ctl.block_cur = (state_reg == S_DISP) && (cmd_reg == CMD_BLOCK);
        ctl.ap_rd     = (state_reg == S_AP_RD) || (state_reg == S_RQ_RD);
        ctl.ap_wr     = (state_reg == S_AP_WR) || (state_reg == S_RQ_WR);
        ctl.sel_cur   = (state_reg == S_RQ_RD) || (state_reg == S_RQ_WR);
        ctl.pick      = (state_reg == S_PICK);
        ctl.pop_chk   = (state_reg == S_POP_CHK);
        ctl.pop_wr    = (state_reg == S_POP_WR);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);
endmodule
`default_nettype wire

// File: hdl/prqs_dpath.sv
`default_nettype none
module prqs_dpath
    import prqs_pkg::*;
#(
    parameter int NUM_LEVELS = 64,
    parameter int NUM_TASKS  = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [4:0] task_id,
    input  wire logic [5:0] prio_level,
    input  wire dp_ctl_t    ctl,
    output dp_stat_t        stat,
    output logic [4:0]      running_task,
    output logic            running_valid,
    output logic [5:0]      running_prio,
    output logic            switched
);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(NUM_TASKS);

    logic [4:0]            task_reg;
    logic [5:0]            prio_reg;
    logic [LW-1:0]         lv_reg;
    logic [NUM_LEVELS-1:0] ready_reg;
    logic [TW-1:0]         cur_id_reg;
    logic [LW-1:0]         cur_lv_reg;
    logic                  present_reg, running_reg, sw_reg;

    logic [TW-1:0]         ap_task, head_rd, tail_rd, link_rd;
    logic [LW-1:0]         ap_lv, ffs;
    logic [NUM_LEVELS-1:0] lowest;
    logic [LW-1:0]         head_addr, tail_addr;
    logic [TW-1:0]         link_addr, head_wd;
    logic                  head_we, tail_we, link_we, lv_ready;

    assign ap_task  = ctl.sel_cur ? cur_id_reg : TW'(task_reg);
    assign ap_lv    = ctl.sel_cur ? cur_lv_reg : LW'(prio_reg);
    assign lv_ready = ready_reg[ap_lv];

    // isolate lowest set bit, then encode its position
    assign lowest = ready_reg & (~ready_reg + NUM_LEVELS'(1));
    always_comb
    begin
        ffs = '0;
        for (int i = 0; i < NUM_LEVELS; i++)
        begin
            if (lowest[i])
            begin
                ffs = ffs | LW'(i);
            end
        end
    end

    assign head_addr = ctl.pick ? ffs : (ctl.ap_wr ? ap_lv : lv_reg);
    assign head_we   = (ctl.ap_wr && !lv_ready) || ctl.pop_wr;
    assign head_wd   = ctl.pop_wr ? link_rd : ap_task;
    assign tail_addr = ctl.pick ? ffs : ap_lv;
    assign tail_we   = ctl.ap_wr;
    assign link_addr = ctl.ap_wr ? tail_rd : head_rd;
    assign link_we   = ctl.ap_wr && lv_ready;

    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_head (
        .clk(clk), .addr(head_addr), .we(head_we), .wdata(head_wd), .rdata(head_rd)
    );
    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_tail (
        .clk(clk), .addr(tail_addr), .we(tail_we), .wdata(ap_task), .rdata(tail_rd)
    );
    prqs_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link (
        .clk(clk), .addr(link_addr), .we(link_we), .wdata(ap_task), .rdata(link_rd)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            task_reg <= task_id;
            prio_reg <= prio_level;
        end
        if (ctl.pick)
        begin
            lv_reg <= ffs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg   <= '0;
            cur_id_reg  <= '0;
            cur_lv_reg  <= '0;
            present_reg <= 1'b0;
            running_reg <= 1'b0;
            sw_reg      <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                sw_reg <= 1'b0;
            end
            if (ctl.block_cur)
            begin
                running_reg <= 1'b0;
            end
            if (ctl.ap_wr && !lv_ready)
            begin
                ready_reg[ap_lv] <= 1'b1;
            end
            if (ctl.pick)
            begin
                cur_id_reg  <= '0;
                cur_lv_reg  <= '0;
                present_reg <= 1'b0;
                running_reg <= 1'b0;
            end
            if (ctl.pop_chk)
            begin
                if (head_rd == tail_rd)
                begin
                    ready_reg[lv_reg] <= 1'b0;
                end
                cur_id_reg  <= head_rd;
                cur_lv_reg  <= lv_reg;
                present_reg <= 1'b1;
                running_reg <= 1'b1;
                sw_reg      <= 1'b1;
            end
        end
    end

    assign stat.ap_ok     = (int'(task_reg) < NUM_TASKS) && (int'(prio_reg) < NUM_LEVELS);
    assign stat.requeue   = present_reg && running_reg;
    assign stat.any_ready = |ready_reg;
    assign stat.last      = (head_rd == tail_rd);

    assign running_task  = 5'(cur_id_reg);
    assign running_valid = present_reg;
    assign running_prio  = 6'(cur_lv_reg);
    assign switched      = sw_reg;
endmodule
`default_nettype wire

// File: hdl/priority_ready_queue_scheduler_unit.sv
`default_nettype none
// Channel     Handshake                 Payload
// ----------  ------------------------  -----------------------------------------
// command     start & !busy             cmd, task_id, prio_level
// result      done (one-cycle strobe)   running_task, running_valid,
//                                       running_prio, switched
//
// One transaction at a time. Make ready reads, then writes its level's head/tail
// entries; schedule re-queues a running task the same way, then pops the head of
// the lowest-numbered ready level; block drops the running flag, then schedules;
// make ready then schedule does both. Head, tail and link RAMs are single-port.
// Reset clears the ready bitmap and current task; RAM contents need no clear.
// The receiver cannot stall: done is high for exactly one cycle.
module priority_ready_queue_scheduler_unit
    import prqs_pkg::*;
#(
    parameter int NUM_LEVELS = 64,
    parameter int NUM_TASKS  = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] cmd,
    input  wire logic [4:0] task_id,
    input  wire logic [5:0] prio_level,
    output logic            done,
    output logic [4:0]      running_task,
    output logic            running_valid,
    output logic [5:0]      running_prio,
    output logic            switched
);
    dp_ctl_t  ctl;
    dp_stat_t stat;

    // sequencer: decodes the command and steps through append and pop
    prqs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .stat(stat), .ctl(ctl), .busy(busy), .done(done)
    );

    // queue tables, ready bitmap, current task
    prqs_dpath #(.NUM_LEVELS(NUM_LEVELS), .NUM_TASKS(NUM_TASKS)) u_dpath (
        .clk(clk), .rst_n(rst_n), .task_id(task_id), .prio_level(prio_level),
        .ctl(ctl), .stat(stat), .running_task(running_task),
        .running_valid(running_valid), .running_prio(running_prio),
        .switched(switched)
    );

    // result strobe ends the transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after done");

    // a transaction is taken up on the cycle after start
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");

    // no current task reports zero id and level
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !running_valid) |-> (running_task == 5'd0 && running_prio == 6'd0))
        else $error("stale current task");

    // a dispatch always leaves a current task
    a_sw_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && switched) |-> running_valid) else $error("switch without task");
endmodule
`default_nettype wire

// File: test/prqs_checker.sv
`default_nettype none
module prqs_checker
    import prqs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic [1:0] cmd,
    input  wire logic [4:0] task_id,
    input  wire logic [5:0] prio_level,
    input  wire logic       done,
    input  wire logic [4:0] running_task,
    input  wire logic       running_valid,
    input  wire logic [5:0] running_prio,
    input  wire logic       switched,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic [4:0] task_no;
        logic       valid;
        logic [5:0] prio;
        logic       sw;
    } sched_out_t;

    // shadow scheduler state
    logic [4:0]  head_tbl [64];
    logic [4:0]  tail_tbl [64];
    logic [4:0]  link_tbl [32];
    logic [63:0] ready_map;
    logic [4:0]  cur_task;
    logic [5:0]  cur_prio;
    logic        cur_present;
    logic        cur_running;

    sched_out_t outcome_q[$];
    int         reported;

    function automatic void append(input logic [4:0] t, input logic [5:0] lv);
        if (ready_map[lv])
        begin
            link_tbl[tail_tbl[lv]] = t;
            tail_tbl[lv] = t;
        end
        else
        begin
            head_tbl[lv] = t;
            tail_tbl[lv] = t;
            ready_map[lv] = 1'b1;
        end
    endfunction

    function automatic logic dispatch();
        logic [4:0] h;
        if (cur_present)
        begin
            if (cur_running)
                append(cur_task, cur_prio);
            cur_present = 1'b0;
            cur_running = 1'b0;
            cur_task = '0;
            cur_prio = '0;
        end
        for (int lv = 0; lv < 64; lv++)
        begin
            if (ready_map[lv])
            begin
                h = head_tbl[lv];
                if (h == tail_tbl[lv])
                    ready_map[lv] = 1'b0;
                else
                    head_tbl[lv] = link_tbl[h];
                cur_task = h;
                cur_prio = 6'(lv);
                cur_present = 1'b1;
                cur_running = 1'b1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic sched_out_t predict(input cmd_code_t c, input logic [4:0] t,
                                           input logic [5:0] lv);
        sched_out_t r;
        logic sw;
        sw = 1'b0;
        case (c)
            CMD_MAKE_READY: append(t, lv);
            CMD_SCHEDULE:   sw = dispatch();
            CMD_MR_SCHED:
            begin
                append(t, lv);
                sw = dispatch();
            end
            default:
            begin
                if (cur_present)
                    cur_running = 1'b0;
                sw = dispatch();
            end
        endcase
        r.task_no = cur_present ? cur_task : '0;
        r.valid   = cur_present;
        r.prio    = cur_present ? cur_prio : '0;
        r.sw      = sw;
        return r;
    endfunction

    function automatic void note_fail(input string what);
        fail_count++;
        if (reported < 10)
        begin
            reported++;
            $display("mismatch: %s", what);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_out_t exp_r;
        if (!rst_n)
        begin
            ready_map   = '0;
            cur_task    = '0;
            cur_prio    = '0;
            cur_present = 1'b0;
            cur_running = 1'b0;
            outcome_q.delete();
            pending     = 0;
        end
        else
        begin
            // result first: the transaction that ends now predates any new start
            if (done)
            begin
                if (outcome_q.size() == 0)
                    note_fail("result with no transaction outstanding");
                else
                begin
                    exp_r = outcome_q.pop_front();
                    if (running_task !== exp_r.task_no)
                        note_fail($sformatf("running_task exp %0d got %0d",
                                            exp_r.task_no, running_task));
                    if (running_valid !== exp_r.valid)
                        note_fail($sformatf("running_valid exp %0d got %0d",
                                            exp_r.valid, running_valid));
                    if (running_prio !== exp_r.prio)
                        note_fail($sformatf("running_prio exp %0d got %0d",
                                            exp_r.prio, running_prio));
                    if (switched !== exp_r.sw)
                        note_fail($sformatf("switched exp %0d got %0d",
                                            exp_r.sw, switched));
                end
            end
            if (start && !busy)
                outcome_q.push_back(predict(cmd_code_t'(cmd), task_id, prio_level));
            pending = outcome_q.size();
        end
    end

    initial
    begin
        fail_count = 0;
        reported   = 0;
        pending    = 0;
    end

endmodule
`default_nettype wire

// File: test/priority_ready_queue_scheduler_unit_tb.sv
`default_nettype none
module priority_ready_queue_scheduler_unit_tb;
    import prqs_pkg::*;

    localparam int N_RANDOM    = 1100;
    localparam int STALL_LIMIT = 400;   // cycles with no transaction before giving up

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] cmd;
    logic [4:0] task_id;
    logic [5:0] prio_level;
    logic       done;
    logic [4:0] running_task;
    logic       running_valid;
    logic [5:0] running_prio;
    logic       switched;
    int         fail_count;
    int         pending;
    int         idle_cycles;

    // tasks queued or running: never made ready again (duplicate enqueue)
    logic [31:0] owned;
    logic        last_valid;
    logic [4:0]  last_task;

    priority_ready_queue_scheduler_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .task_id(task_id), .prio_level(prio_level),
        .done(done), .running_task(running_task), .running_valid(running_valid),
        .running_prio(running_prio), .switched(switched)
    );

    prqs_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .task_id(task_id), .prio_level(prio_level),
        .done(done), .running_task(running_task), .running_valid(running_valid),
        .running_prio(running_prio), .switched(switched),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: any accepted transaction on either channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // who is current, as seen in the last result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid <= 1'b0;
            last_task  <= '0;
        end
        else if (done)
        begin
            last_valid <= running_valid;
            last_task  <= running_task;
        end
    end

    // One command transaction. Waits for the previous result so the current
    // task is known when choosing; block releases it, make ready claims one.
    task automatic issue(input cmd_code_t c, input logic [4:0] t, input logic [5:0] lv,
                         input bit gaps);
        while (pending != 0)
            @(negedge clk);
        if (gaps)
            while ($urandom_range(99) < 17)
                @(negedge clk);
        if (c == CMD_BLOCK && last_valid)
            owned[last_task] = 1'b0;
        if (c == CMD_MAKE_READY || c == CMD_MR_SCHED)
            owned[t] = 1'b1;
        start      <= 1'b1;
        cmd        <= c;
        task_id    <= t;
        prio_level <= lv;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        start      <= 1'b0;
        cmd        <= 2'($urandom);
        task_id    <= 5'($urandom);
        prio_level <= 6'($urandom);
    endtask

    function automatic logic [4:0] pick_free();
        logic [4:0] t;
        t = 5'($urandom);
        while (owned[t])
            t = t + 5'd1;
        return t;
    endfunction

    initial
    begin
        cmd_code_t c;
        logic [5:0] lv;
        bit gaps;
        start      = 1'b0;
        cmd        = CMD_MAKE_READY;
        task_id    = '0;
        prio_level = '0;
        owned      = '0;
        rst_n      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty schedule, block with nothing current, field extremes,
        // FIFO order within a level, level emptying, priority ordering
        issue(CMD_SCHEDULE,   5'd0,  6'd0,  0);
        issue(CMD_BLOCK,      5'd31, 6'd63, 0);
        issue(CMD_MAKE_READY, 5'd31, 6'd63, 0);
        issue(CMD_MAKE_READY, 5'd0,  6'd63, 0);
        issue(CMD_MAKE_READY, 5'd21, 6'd42, 0);
        issue(CMD_SCHEDULE,   5'd0,  6'd0,  0);
        issue(CMD_SCHEDULE,   5'd0,  6'd0,  0);
        issue(CMD_MR_SCHED,   5'd10, 6'd0,  0);
        issue(CMD_MR_SCHED,   5'd5,  6'd21, 0);
        issue(CMD_BLOCK,      5'd0,  6'd0,  0);
        issue(CMD_SCHEDULE,   5'd0,  6'd0,  0);
        issue(CMD_BLOCK,      5'd0,  6'd0,  0);
        issue(CMD_BLOCK,      5'd0,  6'd0,  0);
        issue(CMD_BLOCK,      5'd0,  6'd0,  0);
        issue(CMD_BLOCK,      5'd0,  6'd0,  0);
        issue(CMD_BLOCK,      5'd0,  6'd0,  0);
        issue(CMD_SCHEDULE,   5'd0,  6'd0,  0);

        // random: mostly make-ready and schedule so queues grow deep, blocks
        // keep tasks recycling; a middle stretch runs with no gaps at all
        for (int i = 0; i < N_RANDOM; i++)
        begin
            gaps = !(i >= 400 && i < 600);
            case ($urandom_range(9))
                0, 1, 2, 3: c = CMD_MAKE_READY;
                4, 5:       c = CMD_SCHEDULE;
                6, 7:       c = CMD_MR_SCHED;
                default:    c = CMD_BLOCK;
            endcase
            if ((c == CMD_MAKE_READY || c == CMD_MR_SCHED) && (&owned))
                c = CMD_BLOCK;
            // few distinct levels most of the time so levels hold several tasks
            lv = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(3) * 21);
            if (c == CMD_MAKE_READY || c == CMD_MR_SCHED)
                issue(c, pick_free(), lv, gaps);
            else
                issue(c, 5'($urandom), 6'($urandom), gaps);
        end

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
hdl/prqs_pkg.sv
hdl/prqs_ram.sv
hdl/prqs_ctrl.sv
hdl/prqs_dpath.sv
hdl/priority_ready_queue_scheduler_unit.sv
test/prqs_checker.sv
test/priority_ready_queue_scheduler_unit_tb.sv
